[hw/rtl/cpdi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpdi_pkg
// Shared types, codes and fixed-point helpers for the correspondence PD
// impulse block: command/status structs and Q16.16 round/saturate functions.
// ----------------------------------------------------------------------------
package cpdi_pkg;

	// Register indexes of the configuration port
	typedef logic cfg_idx_t;
	localparam cfg_idx_t REG_SPRING_GAIN  = 1'b0;
	localparam cfg_idx_t REG_DAMPING_GAIN = 1'b1;

	localparam logic [31:0] SPRING_GAIN_RST  = 32'h0001_0000;
	localparam logic [31:0] DAMPING_GAIN_RST = 32'h0000_0000;

	// Operand selection of the per-axis multiplier
	typedef logic [1:0] mul_sel_t;
	localparam mul_sel_t MUL_TERM   = 2'd0; // weight * (obs - pos)
	localparam mul_sel_t MUL_DAMP   = 2'd1; // kd * vel
	localparam mul_sel_t MUL_SPRING = 2'd2; // kp * rounded sum
	localparam mul_sel_t MUL_MASS   = 2'd3; // mass * dv

	// Commands from the controller to the datapath
	typedef struct packed {
		logic     latch;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_en;
		logic     rnd_en;
		logic     bsave_en;
		logic     sub_en;
		logic     dv_en;
		logic     out_load;
		logic     clear;
	} cpdi_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic last_term;
		logic out_free;
	} cpdi_stat_t;

	// Round a 64-bit Q.32 value to Q.16, half up: floor((v + 2^15) / 2^16)
	function automatic logic [48:0] round16(input logic [63:0] v);
		logic [64:0] t;
		t = {v[63], v} + 65'd32768;
		return t[64:16];
	endfunction

	// True when a 49-bit signed value fits in signed 32 bits
	function automatic logic fits32(input logic [48:0] v);
		return (v[48:31] == {18{v[31]}});
	endfunction

	// Saturate a 49-bit signed value to signed 32 bits
	function automatic logic [31:0] sat32(input logic [48:0] v);
		logic [31:0] r;
		if (fits32(v)) begin
			r = v[31:0];
		end else if (v[48]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

	// Saturate a 65-bit signed sum or difference to signed 64 bits
	function automatic logic [63:0] sat64(input logic [64:0] v);
		logic [63:0] r;
		if (v[64] == v[63]) begin
			r = v[63:0];
		end else if (v[64]) begin
			r = 64'h8000_0000_0000_0000;
		end else begin
			r = 64'h7FFF_FFFF_FFFF_FFFF;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/cpdi_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpdi_ctrl
// Sequencer: takes one term, runs the multiply/accumulate steps and, on a
// node's last term, the finishing steps up to loading the output register.
// ----------------------------------------------------------------------------
module cpdi_ctrl
	import cpdi_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  cpdi_stat_t      stat,
	output cpdi_cmd_t       cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL  = 4'd1;
	localparam logic [3:0] ST_ACC  = 4'd2;
	localparam logic [3:0] ST_RND  = 4'd3;
	localparam logic [3:0] ST_MKP  = 4'd4;
	localparam logic [3:0] ST_SUB  = 4'd5;
	localparam logic [3:0] ST_DV   = 4'd6;
	localparam logic [3:0] ST_MMS  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// Take items only while idle
	assign in_stall = (state_q != ST_IDLE);

	// Decode state into commands and next state
	always_comb begin
		cmd     = '0;
		cmd.mul_sel = MUL_TERM;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_TERM;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_en = 1'b1;
				state_d    = stat.last_term ? ST_RND : ST_IDLE;
			end
			ST_RND: begin
				cmd.rnd_en  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DAMP;
				state_d     = ST_MKP;
			end
			ST_MKP: begin
				cmd.bsave_en = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_SPRING;
				state_d      = ST_SUB;
			end
			ST_SUB: begin
				cmd.sub_en = 1'b1;
				state_d    = ST_DV;
			end
			ST_DV: begin
				cmd.dv_en = 1'b1;
				state_d   = ST_MMS;
			end
			ST_MMS: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MASS;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				// Hold until the output register can take the item
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/cpdi_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpdi_lane
// One axis of the datapath: a shared signed multiplier, the saturating
// accumulator and the round/saturate steps of the finishing sequence.
// ----------------------------------------------------------------------------
module cpdi_lane
	import cpdi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  cpdi_cmd_t        cmd,
	input  wire logic [16:0] w,
	input  wire logic [31:0] obs,
	input  wire logic [31:0] pos,
	input  wire logic [31:0] vel,
	input  wire logic [31:0] kp,
	input  wire logic [31:0] kd,
	input  wire logic [31:0] mass,
	output logic      [31:0] imp,
	output logic             imp_clip,
	output logic             clip
);

	logic [63:0]        sum_q;
	logic               clip_q;
	logic [63:0]        prod_q;
	logic [63:0]        b_q;
	logic [31:0]        s_q;
	logic [63:0]        d_q;
	logic [31:0]        dv_q;

	logic signed [32:0] opa;
	logic signed [32:0] opb;
	logic signed [65:0] prod;
	logic [32:0]        dx;
	logic [64:0]        acc_raw;
	logic [64:0]        sub_raw;
	logic [48:0]        sum_rnd;
	logic [48:0]        d_rnd;
	logic [48:0]        imp_rnd;

	// Select multiplier operands
	assign dx = {obs[31], obs} - {pos[31], pos};

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_TERM: begin
				opa = signed'({16'd0, w});
				opb = signed'(dx);
			end
			MUL_DAMP: begin
				opa = signed'({1'b0, kd});
				opb = signed'({vel[31], vel});
			end
			MUL_SPRING: begin
				opa = signed'({1'b0, kp});
				opb = signed'({s_q[31], s_q});
			end
			MUL_MASS: begin
				opa = signed'({1'b0, mass});
				opb = signed'({dv_q[31], dv_q});
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign prod = opa * opb;

	// Wide add, subtract and rounding
	assign acc_raw = {sum_q[63], sum_q} + {prod_q[63], prod_q};
	assign sub_raw = {prod_q[63], prod_q} - {b_q[63], b_q};
	assign sum_rnd = round16(sum_q);
	assign d_rnd   = round16(d_q);
	assign imp_rnd = round16(prod_q);

	assign imp      = sat32(imp_rnd);
	assign imp_clip = !fits32(imp_rnd);
	assign clip     = clip_q;

	// Accumulator and node clip flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			clip_q <= 1'b0;
		end else if (cmd.clear) begin
			sum_q  <= '0;
			clip_q <= 1'b0;
		end else begin
			if (cmd.acc_en) begin
				sum_q <= sat64(acc_raw);
			end
			if ((cmd.acc_en && (acc_raw[64] != acc_raw[63])) ||
			    (cmd.rnd_en && !fits32(sum_rnd)) ||
			    (cmd.sub_en && (sub_raw[64] != sub_raw[63])) ||
			    (cmd.dv_en && !fits32(d_rnd))) begin
				clip_q <= 1'b1;
			end
		end
	end

	// Working registers of the finishing sequence
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= prod[63:0];
		end
		if (cmd.bsave_en) begin
			b_q <= prod_q;
		end
		if (cmd.rnd_en) begin
			s_q <= sat32(sum_rnd);
		end
		if (cmd.sub_en) begin
			d_q <= sat64(sub_raw);
		end
		if (cmd.dv_en) begin
			dv_q <= sat32(d_rnd);
		end
	end

endmodule
`default_nettype wire

[hw/rtl/cpdi_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpdi_dp
// Datapath: gain registers, input item latch, three axis lanes and the
// output register that holds a finished impulse until it is taken.
// ----------------------------------------------------------------------------
module cpdi_dp
	import cpdi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  cfg_idx_t         cfg_index,
	input  wire logic [31:0] cfg_wdata,
	input  cpdi_cmd_t        cmd,
	output cpdi_stat_t       stat,
	input  wire logic [16:0] weight,
	input  wire logic [31:0] obs_x,
	input  wire logic [31:0] obs_y,
	input  wire logic [31:0] obs_z,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic [31:0] vel_x,
	input  wire logic [31:0] vel_y,
	input  wire logic [31:0] vel_z,
	input  wire logic [31:0] node_mass,
	input  wire logic        last_term,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] impulse_x,
	output logic      [31:0] impulse_y,
	output logic      [31:0] impulse_z,
	output logic             saturated
);

	logic [31:0] kp_q;
	logic [31:0] kd_q;
	logic [16:0] w_q;
	logic [31:0] obs_q [3];
	logic [31:0] pos_q [3];
	logic [31:0] vel_q [3];
	logic [31:0] mass_q;
	logic        last_q;
	logic        out_valid_q;
	logic [31:0] imp_q [3];
	logic        sat_q;

	logic [31:0] imp_d [3];
	logic [2:0]  imp_clip;
	logic [2:0]  lane_clip;

	// Gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= SPRING_GAIN_RST;
			kd_q <= DAMPING_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPRING_GAIN:  kp_q <= cfg_wdata;
				REG_DAMPING_GAIN: kd_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			w_q      <= weight;
			obs_q[0] <= obs_x;
			obs_q[1] <= obs_y;
			obs_q[2] <= obs_z;
			pos_q[0] <= pos_x;
			pos_q[1] <= pos_y;
			pos_q[2] <= pos_z;
			vel_q[0] <= vel_x;
			vel_q[1] <= vel_y;
			vel_q[2] <= vel_z;
			mass_q   <= node_mass;
			last_q   <= last_term;
		end
	end

	// One lane per axis
	for (genvar i = 0; i < 3; i++) begin : g_lane
		cpdi_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.w        (w_q),
			.obs      (obs_q[i]),
			.pos      (pos_q[i]),
			.vel      (vel_q[i]),
			.kp       (kp_q),
			.kd       (kd_q),
			.mass     (mass_q),
			.imp      (imp_d[i]),
			.imp_clip (imp_clip[i]),
			.clip     (lane_clip[i])
		);
	end

	// Output register: load when empty or being taken, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			imp_q[0] <= imp_d[0];
			imp_q[1] <= imp_d[1];
			imp_q[2] <= imp_d[2];
			sat_q    <= (|lane_clip) | (|imp_clip);
		end
	end

	assign stat.last_term = last_q;
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign impulse_x = imp_q[0];
	assign impulse_y = imp_q[1];
	assign impulse_z = imp_q[2];
	assign saturated = sat_q;

endmodule
`default_nettype wire

[hw/rtl/correspondence_pd_impulse_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// correspondence_pd_impulse_top
// Damped spring impulse per tracked node from weighted correspondence terms.
// ----------------------------------------------------------------------------
// Each accepted item is one correspondence term of the current node; the
// block accumulates weight * (obs - pos) per axis in saturating Q31.32 sums.
// A term without last_term runs the latch, multiply and accumulate steps; a
// term with last_term then runs the finish mass * (kp * sum - kd * vel) through
// one shared multiplier per axis in its damping, spring and mass multiply steps
// with round/saturate steps between, plus any wait for the output register.
// One item is in work at a time; a finished impulse sits in the output
// register while the next term is taken. saturated reports any clip in the
// node's sums or finishing steps. The user must set gains via cfg_we/cfg_index/
// cfg_wdata only while the block is idle (unenforced); reset kp = 1.0, kd = 0.
// ----------------------------------------------------------------------------
module correspondence_pd_impulse_top
	import cpdi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [16:0] weight,
	input  wire logic [31:0] obs_x,
	input  wire logic [31:0] obs_y,
	input  wire logic [31:0] obs_z,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic [31:0] vel_x,
	input  wire logic [31:0] vel_y,
	input  wire logic [31:0] vel_z,
	input  wire logic [31:0] node_mass,
	input  wire logic        last_term,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] impulse_x,
	output logic      [31:0] impulse_y,
	output logic      [31:0] impulse_z,
	output logic             saturated
);

	cpdi_cmd_t  cmd;
	cpdi_stat_t stat;

	cpdi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	cpdi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.weight    (weight),
		.obs_x     (obs_x),
		.obs_y     (obs_y),
		.obs_z     (obs_z),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.vel_z     (vel_z),
		.node_mass (node_mass),
		.last_term (last_term),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.impulse_x (impulse_x),
		.impulse_y (impulse_y),
		.impulse_z (impulse_z),
		.saturated (saturated)
	);

	// An accepted item blocks the input for at least the next cycle
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted on consecutive cycles");

	// A result is loaded only into a free output register
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("output register overwritten while held");

	// A loaded result shows as valid in the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not presented");

	// Multiply and accumulate steps only run while the input is closed
	a_acc_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc_en || cmd.mul_en) |-> in_stall)
		else $error("datapath busy while input open");

endmodule
`default_nettype wire
